FILE: rtl/core/ldru_pkg.sv
// Shared types and constants for the layer depth register unit.
// No dependencies; imported by ldru_regfile and layer_depth_register_unit.
`default_nettype none

package ldru_pkg;

    // Request kinds carried on the input tuser field
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_DEPTH = 2'd2,
        ACT_FRONT = 2'd3
    } t_action;

    // Bus register map
    localparam logic [15:0] ADDR_CTRL   = 16'h21c0;
    localparam logic [15:0] ADDR_FAR_LO = 16'h21c1;
    localparam logic [15:0] ADDR_FAR_HI = 16'h21c2;
    localparam logic [15:0] ADDR_LAYERS = 16'h21c4;

    // Offsets inside one layer's four-byte slot
    localparam logic [1:0] OFF_BASE_LO = 2'd0;
    localparam logic [1:0] OFF_BASE_HI = 2'd1;
    localparam logic [1:0] OFF_PALETTE = 2'd2;
    localparam logic [1:0] OFF_PRIO    = 2'd3;

    // Reset values and the depth saturation bound
    localparam logic [15:0] FAR_RESET   = 16'hffff;
    localparam logic [7:0]  PRIO_RESET  = 8'h10;
    localparam logic [15:0] DEPTH_MAX   = 16'hffff;

    // Widths of the stream payloads
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 24;

    typedef struct packed {
        logic clamp_enable;
        logic priority_override;
        logic unit_enable;
    } t_ctrl;

    typedef struct packed {
        logic [15:0] base;
        logic [7:0]  palette_scale;
        logic [7:0]  priority_scale;
    } t_layer_regs;

    // Decoded bus address
    typedef struct packed {
        logic       ctrl;
        logic       far_lo;
        logic       far_hi;
        logic       layer_hit;
        logic [1:0] offset;
    } t_bus_dec;

endpackage

`default_nettype wire

FILE: rtl/core/ldru_regfile.sv
// Register file of the layer depth unit: control, far depth and per-layer fields.
// Depends on ldru_pkg; the caller supplies the decoded address and layer index.
`default_nettype none

module ldru_regfile
    import ldru_pkg::*;
#(
    parameter int NUM_LAYERS = 5,
    parameter int LAYER_W    = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire t_bus_dec           i_dec,
    input  wire logic [LAYER_W-1:0] i_idx,
    input  wire logic [7:0]         i_wr_data,
    output t_ctrl                   o_ctrl,
    output logic [15:0]             o_far,
    output t_layer_regs             o_layer
);

    t_ctrl       r_ctrl;
    logic [15:0] r_far;
    t_layer_regs r_layer [NUM_LAYERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '{clamp_enable: 1'b1, priority_override: 1'b0, unit_enable: 1'b0};
            r_far  <= FAR_RESET;
            for (int i = 0; i < NUM_LAYERS; i++) begin
                r_layer[i] <= '{base: 16'h0000, palette_scale: 8'h00,
                                priority_scale: PRIO_RESET};
            end
        end else if (i_wr_en) begin
            if (i_dec.ctrl) begin
                r_ctrl <= '{clamp_enable: i_wr_data[2], priority_override: i_wr_data[1],
                            unit_enable: i_wr_data[0]};
            end
            if (i_dec.far_lo) begin
                r_far[7:0] <= i_wr_data;
            end
            if (i_dec.far_hi) begin
                r_far[15:8] <= i_wr_data;
            end
            for (int i = 0; i < NUM_LAYERS; i++) begin
                if (i_dec.layer_hit && (i_idx == LAYER_W'(i))) begin
                    unique case (i_dec.offset)
                        OFF_BASE_LO: r_layer[i].base[7:0]      <= i_wr_data;
                        OFF_BASE_HI: r_layer[i].base[15:8]     <= i_wr_data;
                        OFF_PALETTE: r_layer[i].palette_scale  <= i_wr_data;
                        OFF_PRIO:    r_layer[i].priority_scale <= i_wr_data;
                        default:     r_layer[i].base           <= r_layer[i].base;
                    endcase
                end
            end
        end
    end

    always_comb begin
        if (32'(i_idx) < NUM_LAYERS) begin
            o_layer = r_layer[i_idx];
        end else begin
            o_layer = '0;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_far  = r_far;

endmodule

`default_nettype wire

FILE: rtl/core/layer_depth_register_unit.sv
// A request accepted passes through the input register and then the result register to the master side.
// Throughput: one request per cycle; the input register and the result register move
// together, so the only stall is backpressure from the master side.
// Register writes take effect for the request that follows directly behind them.
// Reset (synchronous, active low) empties both stages and loads the register defaults.
`default_nettype none

module layer_depth_register_unit
    import ldru_pkg::*;
#(
    parameter int NUM_LAYERS = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] address, [23:16] write_data, [26:24] layer, [30:27] priority_req,
    // [38:31] color, [54:39] above_depth, [55] above_valid, [71:56] below_depth,
    // [72] below_valid, [79:73] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] read_data, [23:8] depth_out
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int LAYER_W    = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int SLOT_BYTES = 4 * NUM_LAYERS;

    // ---------------------------------------------------------------
    // Input register: hold one request until the result stage is free
    // ---------------------------------------------------------------
    logic        r_in_valid;
    t_action     r_action;
    logic [15:0] r_address;
    logic [7:0]  r_write_data;
    logic [2:0]  r_layer;
    logic [3:0]  r_priority_req;
    logic [7:0]  r_color;
    logic [15:0] r_above_depth;
    logic        r_above_valid;
    logic [15:0] r_below_depth;
    logic        r_below_valid;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [15:0] r_depth_out;

    logic w_out_free;   // result stage can take a new result this cycle
    logic w_advance;    // request in the input register moves to the result stage

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Payload: capture on every accepted request, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action       <= t_action'(s_axis_tuser);
            r_address      <= s_axis_tdata[15:0];
            r_write_data   <= s_axis_tdata[23:16];
            r_layer        <= s_axis_tdata[26:24];
            r_priority_req <= s_axis_tdata[30:27];
            r_color        <= s_axis_tdata[38:31];
            r_above_depth  <= s_axis_tdata[54:39];
            r_above_valid  <= s_axis_tdata[55];
            r_below_depth  <= s_axis_tdata[71:56];
            r_below_valid  <= s_axis_tdata[72];
        end
    end

    // ---------------------------------------------------------------
    // Address decode: fixed registers, then the per-layer slots
    // ---------------------------------------------------------------
    t_bus_dec            w_dec;
    logic [15:0]         w_rel;
    logic [LAYER_W-1:0]  w_addr_idx;
    logic [LAYER_W-1:0]  w_query_idx;
    logic [LAYER_W-1:0]  w_idx;

    assign w_rel      = r_address - ADDR_LAYERS;
    assign w_addr_idx = w_rel[2 +: LAYER_W];

    always_comb begin
        w_dec.ctrl      = (r_address == ADDR_CTRL);
        w_dec.far_lo    = (r_address == ADDR_FAR_LO);
        w_dec.far_hi    = (r_address == ADDR_FAR_HI);
        w_dec.layer_hit = (r_address >= ADDR_LAYERS) && (32'(w_rel) < SLOT_BYTES);
        w_dec.offset    = w_rel[1:0];
    end

    // Fold out-of-range query layers onto the object layer (the last one)
    always_comb begin
        if (32'(r_layer) >= NUM_LAYERS) begin
            w_query_idx = LAYER_W'(NUM_LAYERS - 1);
        end else begin
            w_query_idx = LAYER_W'(r_layer);
        end
    end

    // One layer read port serves both bus reads and depth queries
    assign w_idx = (r_action == ACT_DEPTH) ? w_query_idx : w_addr_idx;

    // ---------------------------------------------------------------
    // Register file: write when a write request leaves the input register
    // ---------------------------------------------------------------
    t_ctrl       w_ctrl;
    logic [15:0] w_far;
    t_layer_regs w_layer;

    ldru_regfile #(
        .NUM_LAYERS (NUM_LAYERS),
        .LAYER_W    (LAYER_W)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_advance && (r_action == ACT_WRITE)),
        .i_dec     (w_dec),
        .i_idx     (w_idx),
        .i_wr_data (r_write_data),
        .o_ctrl    (w_ctrl),
        .o_far     (w_far),
        .o_layer   (w_layer)
    );

    // ---------------------------------------------------------------
    // Bus read mux; unmapped addresses read as zero
    // ---------------------------------------------------------------
    logic [7:0] w_bus_byte;

    always_comb begin
        priority if (w_dec.ctrl) begin
            w_bus_byte = {5'b0, w_ctrl.clamp_enable, w_ctrl.priority_override,
                          w_ctrl.unit_enable};
        end else if (w_dec.far_lo) begin
            w_bus_byte = w_far[7:0];
        end else if (w_dec.far_hi) begin
            w_bus_byte = w_far[15:8];
        end else if (w_dec.layer_hit) begin
            unique case (w_dec.offset)
                OFF_BASE_LO: w_bus_byte = w_layer.base[7:0];
                OFF_BASE_HI: w_bus_byte = w_layer.base[15:8];
                OFF_PALETTE: w_bus_byte = w_layer.palette_scale;
                OFF_PRIO:    w_bus_byte = w_layer.priority_scale;
                default:     w_bus_byte = 8'h00;
            endcase
        end else begin
            w_bus_byte = 8'h00;
        end
    end

    // ---------------------------------------------------------------
    // Depth datapath: base + prio_scale*prio + palette_scale*color.
    // The largest sum fits in 18 bits; saturate or wrap to 16.
    // ---------------------------------------------------------------
    logic [11:0] w_prio_prod;
    logic [15:0] w_color_prod;
    logic [17:0] w_sum;
    logic [15:0] w_layer_depth;
    logic [15:0] w_front_depth;

    assign w_prio_prod  = w_layer.priority_scale * r_priority_req;
    assign w_color_prod = w_layer.palette_scale * r_color;
    assign w_sum        = {2'b00, w_layer.base} + 18'(w_prio_prod) + 18'(w_color_prod);

    always_comb begin
        if (w_ctrl.clamp_enable && (w_sum[17:16] != 2'b00)) begin
            w_layer_depth = DEPTH_MAX;
        end else begin
            w_layer_depth = w_sum[15:0];
        end
    end

    // Front select: above wins, then below, then far
    always_comb begin
        priority if (r_above_valid) begin
            w_front_depth = r_above_depth;
        end else if (r_below_valid) begin
            w_front_depth = r_below_depth;
        end else begin
            w_front_depth = w_far;
        end
    end

    // ---------------------------------------------------------------
    // Result stage
    // ---------------------------------------------------------------
    logic [7:0]  n_read_data;
    logic [15:0] n_depth_out;

    always_comb begin
        n_read_data = 8'h00;
        n_depth_out = 16'h0000;
        unique case (r_action)
            ACT_READ:  n_read_data = w_bus_byte;
            ACT_WRITE: n_read_data = 8'h00;
            ACT_DEPTH: n_depth_out = w_ctrl.unit_enable ? w_layer_depth : w_far;
            ACT_FRONT: n_depth_out = w_ctrl.unit_enable ? w_front_depth : w_far;
            default:   n_depth_out = 16'h0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_read_data <= n_read_data;
            r_depth_out <= n_depth_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_depth_out, r_read_data};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // A request held in the input register is not dropped while the result stage stalls
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid)
        else $error("input request lost under backpressure");

    // A control write is visible to the very next request
    a_ctrl_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_action == ACT_WRITE) && w_dec.ctrl
        |=> w_ctrl.unit_enable == $past(r_write_data[0]))
        else $error("control write not applied");

    // Queries while disabled return the far depth
    a_disabled_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_ctrl.unit_enable
        && ((r_action == ACT_DEPTH) || (r_action == ACT_FRONT))
        |=> r_depth_out == $past(w_far))
        else $error("disabled query did not return far depth");

endmodule

`default_nettype wire
